// ===== rtl/core/etv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression token validator package
// Transaction types, token classes, parser modes and verdict codes.
// ----------------------------------------------------------------------------
package etv_pkg;

  typedef enum logic [2:0] {
    KIND_NUMBER = 3'd0,
    KIND_SYMBOL = 3'd1,
    KIND_FUNC   = 3'd2,
    KIND_OPEN   = 3'd3,
    KIND_CLOSE  = 3'd4,
    KIND_OPER   = 3'd5,
    KIND_COMMA  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_SYMBOL = 3'd2,
    MODE_FUNC   = 3'd3,
    MODE_OPEN   = 3'd4,
    MODE_CLOSE  = 3'd5,
    MODE_OPER   = 3'd6,
    MODE_COMMA  = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    VERD_PENDING  = 4'd0,
    VERD_VALID    = 4'd1,
    VERD_UNEXP    = 4'd2,
    VERD_PAREN    = 4'd3,
    VERD_UNKFUNC  = 4'd4,
    VERD_COMMA    = 4'd5,
    VERD_TOO_MANY = 4'd6,
    VERD_TOO_FEW  = 4'd7,
    VERD_OVERFLOW = 4'd8,
    VERD_EMPTY    = 4'd9
  } verdict_e;

  localparam int unsigned OpenDepthW = 7;

  typedef struct packed {
    logic       func;
    logic [2:0] token_kind;
    logic       op_unary;
    logic       op_right_assoc;
    logic       op_postfix_power;
    logic       func_known;
    logic [3:0] func_arity;
  } etv_in_t;

  typedef struct packed {
    logic [3:0]            verdict;
    logic [OpenDepthW-1:0] open_depth;
  } etv_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/expression_token_validator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression token validator unit
// Checks calculator expression syntax one classified token per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries either one classified token or an end
// marker. Every input transaction produces exactly one output transaction
// with the verdict so far and the number of unclosed parentheses.
// The first error found is held and reported until the end marker arrives.
// The end marker returns the final verdict and clears all parser state.
// Open function calls live in a call memory with a registered read port.
// The top entry of the next stack is read every cycle, one below the next
// stack count, and a write to that same address is forwarded into the read data.
// The result is registered, and a new transaction is accepted every cycle
// unless the output stalls; the forwarded top-of-stack read keeps that rate.
// The result sits in an output register. While it waits under a stall,
// no new input is taken; once it is taken, the next result loads at once.
// Reset empties the stack and returns the parser to its initial mode.
// ----------------------------------------------------------------------------
module expression_token_validator_unit
  import etv_pkg::*;
#(
  parameter int unsigned MAX_PAREN_DEPTH = 64,
  parameter int unsigned MAX_CALL_NEST   = 16,
  parameter int unsigned MAX_ARITY       = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire etv_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output etv_out_t     out_data_o
);

  localparam int unsigned PW = $clog2(MAX_PAREN_DEPTH + 1);
  localparam int unsigned CW = $clog2(MAX_CALL_NEST + 1);
  localparam int unsigned AW = (MAX_CALL_NEST > 1) ? $clog2(MAX_CALL_NEST) : 1;
  localparam int unsigned LW = $clog2(MAX_ARITY + 1);
  localparam int unsigned EW = PW + LW;

  mode_e    mode_q, mode_d;
  logic [PW-1:0] paren_q, paren_d;
  logic [CW-1:0] count_q, count_d;
  verdict_e error_q, error_d;
  logic     seen_q, seen_d;
  logic     prev_un_q, prev_un_d;
  logic     prev_ra_q, prev_ra_d;

  logic [EW-1:0] stack_mem [MAX_CALL_NEST];
  logic [EW-1:0] top_q;
  logic [PW-1:0] top_depth;
  logic [LW-1:0] top_left;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_wdata;
  logic [LW-1:0] arity_sat;

  logic     fire;
  logic     out_valid_q;
  etv_out_t out_data_q;
  etv_out_t res_d;
  verdict_e final_verdict;

  assign fire       = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign top_depth  = top_q[EW-1:LW];
  assign top_left   = top_q[LW-1:0];
  assign arity_sat  = (32'(in_data_i.func_arity) > MAX_ARITY) ? LW'(MAX_ARITY)
                                                              : LW'(in_data_i.func_arity);
  assign mem_raddr  = AW'(count_d - 1'b1);

  always_comb begin
    mode_d    = mode_q;
    paren_d   = paren_q;
    count_d   = count_q;
    error_d   = error_q;
    seen_d    = seen_q;
    prev_un_d = prev_un_q;
    prev_ra_d = prev_ra_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(count_q);
    mem_wdata = {paren_q, arity_sat};
    if (fire && in_data_i.func) begin
      mode_d    = MODE_INIT;
      paren_d   = '0;
      count_d   = '0;
      error_d   = VERD_PENDING;
      seen_d    = 1'b0;
      prev_un_d = 1'b0;
      prev_ra_d = 1'b0;
    end else if (fire && error_q == VERD_PENDING) begin
      seen_d    = 1'b1;
      prev_un_d = in_data_i.op_unary;
      prev_ra_d = in_data_i.op_right_assoc;
      error_d   = VERD_UNEXP;
      case (mode_q)
        MODE_INIT, MODE_OPER, MODE_OPEN, MODE_COMMA: begin
          if (in_data_i.token_kind == KIND_NUMBER) begin
            mode_d  = MODE_NUMBER;
            error_d = VERD_PENDING;
          end else if (in_data_i.token_kind == KIND_SYMBOL) begin
            mode_d  = MODE_SYMBOL;
            error_d = VERD_PENDING;
          end else if (in_data_i.token_kind == KIND_FUNC) begin
            mode_d = MODE_FUNC;
            if (!in_data_i.func_known) begin
              error_d = VERD_UNKFUNC;
            end else if (count_q == CW'(MAX_CALL_NEST)) begin
              error_d = VERD_OVERFLOW;
            end else begin
              error_d   = VERD_PENDING;
              mem_we    = 1'b1;
              mem_waddr = AW'(count_q);
              mem_wdata = {paren_q, arity_sat};
              count_d   = count_q + 1'b1;
            end
          end else if (in_data_i.token_kind == KIND_OPEN) begin
            mode_d = MODE_OPEN;
            if (paren_q == PW'(MAX_PAREN_DEPTH)) begin
              error_d = VERD_OVERFLOW;
            end else begin
              error_d = VERD_PENDING;
              paren_d = paren_q + 1'b1;
            end
          end else if (in_data_i.token_kind == KIND_OPER) begin
            if (mode_q == MODE_INIT && in_data_i.op_postfix_power) begin
              mode_d  = MODE_OPER;
              error_d = VERD_PENDING;
            end else if (mode_q == MODE_OPER && in_data_i.op_unary) begin
              error_d = VERD_PENDING;
            end else if (mode_q == MODE_OPEN && in_data_i.op_unary &&
                         in_data_i.op_right_assoc) begin
              mode_d  = MODE_OPER;
              error_d = VERD_PENDING;
            end
          end
        end
        MODE_NUMBER, MODE_SYMBOL, MODE_CLOSE: begin
          if (in_data_i.token_kind == KIND_OPER) begin
            mode_d  = MODE_OPER;
            error_d = VERD_PENDING;
          end else if (in_data_i.token_kind == KIND_COMMA) begin
            mode_d = MODE_COMMA;
            if (count_q == '0 || paren_q == '0 || top_depth != paren_q - 1'b1) begin
              error_d = VERD_COMMA;
            end else if (top_left <= LW'(1)) begin
              error_d = VERD_TOO_MANY;
            end else begin
              error_d   = VERD_PENDING;
              mem_we    = 1'b1;
              mem_waddr = AW'(count_q - 1'b1);
              mem_wdata = {top_depth, top_left - 1'b1};
            end
          end else if (in_data_i.token_kind == KIND_CLOSE) begin
            mode_d = MODE_CLOSE;
            if (paren_q == '0) begin
              error_d = VERD_PAREN;
            end else begin
              paren_d = paren_q - 1'b1;
              error_d = VERD_PENDING;
              if (count_q != '0 && top_depth == paren_q - 1'b1) begin
                if (top_left != LW'(1)) begin
                  error_d = VERD_TOO_FEW;
                end else begin
                  count_d = count_q - 1'b1;
                end
              end
            end
          end
        end
        MODE_FUNC: begin
          if (in_data_i.token_kind == KIND_OPEN) begin
            mode_d = MODE_OPEN;
            if (paren_q == PW'(MAX_PAREN_DEPTH)) begin
              error_d = VERD_OVERFLOW;
            end else begin
              error_d = VERD_PENDING;
              paren_d = paren_q + 1'b1;
            end
          end
        end
        default: begin
          error_d = VERD_UNEXP;
        end
      endcase
    end
  end

  always_comb begin
    if (error_q != VERD_PENDING) begin
      final_verdict = error_q;
    end else if (paren_q != '0) begin
      final_verdict = VERD_PAREN;
    end else if (!seen_q) begin
      final_verdict = VERD_EMPTY;
    end else if (mode_q == MODE_NUMBER || mode_q == MODE_SYMBOL || mode_q == MODE_CLOSE) begin
      final_verdict = VERD_VALID;
    end else if (mode_q == MODE_OPER && prev_un_q && !prev_ra_q) begin
      final_verdict = VERD_VALID;
    end else begin
      final_verdict = VERD_UNEXP;
    end
    if (in_data_i.func) begin
      res_d.verdict    = final_verdict;
      res_d.open_depth = '0;
    end else begin
      res_d.verdict    = error_d;
      res_d.open_depth = OpenDepthW'(paren_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_INIT;
      paren_q     <= '0;
      count_q     <= '0;
      error_q     <= VERD_PENDING;
      seen_q      <= 1'b0;
      prev_un_q   <= 1'b0;
      prev_ra_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      paren_q   <= paren_d;
      count_q   <= count_d;
      error_q   <= error_d;
      seen_q    <= seen_d;
      prev_un_q <= prev_un_d;
      prev_ra_q <= prev_ra_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && mem_waddr == mem_raddr) begin
      top_q <= mem_wdata;
    end else begin
      top_q <= stack_mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/etv_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Expression token validator checker
// Port-level properties of the validator, attached to the validator unit by bind.
// ----------------------------------------------------------------------------
module etv_checker
  import etv_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire etv_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output transaction changed.");

  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("Accepted input transaction produced no output.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled while the output register was empty.");

  a_valid_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERD_VALID |-> out_data_o.open_depth == '0)
    else $error("Valid verdict reported with open parentheses.");

  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.verdict <= VERD_EMPTY)
    else $error("Verdict code out of range.");

endmodule

bind expression_token_validator_unit etv_checker u_etv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
